// File: hw/rtl/dual_timer_prescaled_modes_defines.svh
// Assertion macros for the dual prescaled timer block.
// Included by the modules that carry assertions; compiled out when SYNTH is set.
`ifndef DUAL_TIMER_PRESCALED_MODES_DEFINES_SVH
`define DUAL_TIMER_PRESCALED_MODES_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define DTPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtpm assertion failed");
// next-cycle implication
`define DTPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtpm assertion failed");
`else
`define DTPM_ASSERT_SAME(label, ante, cons)
`define DTPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/dtpm_pkg.sv
// Shared types and constants for the dual prescaled timer block.
// No dependencies; used by dtpm_cfg, dtpm_step and the top level.
package dtpm_pkg;

  localparam int TICK_BITS_DEF = 16;
  localparam int ELAPSED_W     = 16;
  localparam int CNT_W         = 8;
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 32;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD0 = 2'd1,
    CMD_LOAD1 = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ADD          = 2'd0,
    MODE_INDEP        = 2'd1,
    MODE_CASCADE      = 2'd2,
    MODE_CASCADE_FLAG = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_T0_SHORT  = 3'd1,
    REG_T0_WIDE   = 3'd2,
    REG_T1_DIV    = 3'd3,
    REG_T0_EN     = 3'd4,
    REG_T1_EN     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] t0_div_short;
    logic [2:0] t0_div_wide;
    logic [1:0] t1_div;
    logic       t0_en;
    logic       t1_en;
  } cfg_t;

  typedef struct packed {
    logic             irq;
    logic [CNT_W-1:0] t0_count;
    logic [CNT_W-1:0] t1_count;
    logic             t0_flag;
    logic             t1_flag;
  } res_t;

endpackage

// File: hw/rtl/dtpm_cfg.sv
// APB-style register file for timer mode, dividers and enables.
// Depends on dtpm_pkg.
module dtpm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtpm_pkg::APB_AW-1:0]   paddr,
  input  logic [dtpm_pkg::APB_DW-1:0]   pwdata,
  output logic [dtpm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output dtpm_pkg::cfg_t                cfg
);
  import dtpm_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:     cfg_r.mode         <= mode_t'(pwdata[1:0]);
        REG_T0_SHORT: cfg_r.t0_div_short <= pwdata[1:0];
        REG_T0_WIDE:  cfg_r.t0_div_wide  <= pwdata[2:0];
        REG_T1_DIV:   cfg_r.t1_div       <= pwdata[1:0];
        REG_T0_EN:    cfg_r.t0_en        <= pwdata[0];
        REG_T1_EN:    cfg_r.t1_en        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_MODE:     prdata[1:0] = cfg_r.mode;
      REG_T0_SHORT: prdata[1:0] = cfg_r.t0_div_short;
      REG_T0_WIDE:  prdata[2:0] = cfg_r.t0_div_wide;
      REG_T1_DIV:   prdata[1:0] = cfg_r.t1_div;
      REG_T0_EN:    prdata[0]   = cfg_r.t0_en;
      REG_T1_EN:    prdata[0]   = cfg_r.t1_en;
      default:      prdata      = '0;
    endcase
  end

endmodule

// File: hw/rtl/dtpm_step.sv
// Timer state registers and the one-word update for tick, load and clear.
// Depends on dtpm_pkg; the state registers double as the result count/flag outputs.
module dtpm_step #(
  parameter int TICK_BITS = dtpm_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dtpm_pkg::cfg_t                  cfg,
  input  logic                            step_en,
  input  dtpm_pkg::cmd_t                  cmd,
  input  logic [dtpm_pkg::ELAPSED_W-1:0]  elapsed,
  input  logic [dtpm_pkg::CNT_W-1:0]      wv,
  output logic                            irq_nxt,
  output dtpm_pkg::res_t                  state
);
  import dtpm_pkg::*;

  localparam int EffW = (TICK_BITS < ELAPSED_W) ? TICK_BITS : ELAPSED_W;
  localparam logic [ELAPSED_W-1:0] TickMask = ELAPSED_W'((32'd1 << EffW) - 32'd1);

  logic [CNT_W-1:0] rest0_r, rest0_nxt, rest1_r, rest1_nxt;
  logic [CNT_W-1:0] v0_r, v0_nxt, v1_r, v1_nxt;
  logic [1:0]       st_r, st_nxt;

  logic [ELAPSED_W-1:0] el;
  logic [3:0]           sh0, sh1;
  logic [ELAPSED_W:0]   tot0, tot1, inc0, inc1;
  logic [ELAPSED_W+1:0] val0, val1;
  logic [10:0]          high;
  logic                 ovf0;

  assign el = elapsed & TickMask;

  always_comb begin
    rest0_nxt = rest0_r;
    rest1_nxt = rest1_r;
    v0_nxt    = v0_r;
    v1_nxt    = v1_r;
    st_nxt    = st_r;
    irq_nxt   = 1'b0;

    sh0  = (cfg.mode == MODE_INDEP) ? {2'b00, cfg.t0_div_short} + 4'd1
                                    : {1'b0, cfg.t0_div_wide} + 4'd1;
    tot0 = {{(ELAPSED_W+1-CNT_W){1'b0}}, rest0_r} + {1'b0, el};
    inc0 = tot0 >> sh0;
    val0 = {{(ELAPSED_W+2-CNT_W){1'b0}}, v0_r} + {1'b0, inc0};
    ovf0 = |val0[ELAPSED_W+1:CNT_W];
    high = {3'b000, v1_r} + {1'b0, val0[CNT_W+9:CNT_W]};

    sh1  = {1'b0, cfg.t1_div, 1'b0} + 4'd2;
    tot1 = {{(ELAPSED_W+1-CNT_W){1'b0}}, rest1_r} + {1'b0, el};
    inc1 = tot1 >> sh1;
    val1 = {{(ELAPSED_W+2-CNT_W){1'b0}}, v1_r} + {1'b0, inc1};

    case (cmd)
      CMD_TICK: begin
        if (cfg.t0_en) begin
          rest0_nxt = CNT_W'(tot0 & ((17'd1 << sh0) - 17'd1));
          if (!cfg.mode[1]) begin
            if (ovf0 && (cfg.mode == MODE_INDEP || cfg.t1_en)) begin
              st_nxt[0] = 1'b1;
              irq_nxt   = 1'b1;
            end
            // add-reload mode folds timer1 into timer0 each tick
            v0_nxt = (cfg.mode == MODE_ADD) ? val0[CNT_W-1:0] + v1_r : val0[CNT_W-1:0];
          end else begin
            v0_nxt = val0[CNT_W-1:0];
            if (ovf0) begin
              if (cfg.mode == MODE_CASCADE_FLAG) begin
                st_nxt[0] = 1'b1;
                irq_nxt   = 1'b1;
              end
              // full lap count carries into timer1
              if (cfg.mode == MODE_CASCADE || cfg.t1_en) begin
                v1_nxt = high[CNT_W-1:0];
                if (|high[10:CNT_W]) begin
                  st_nxt[1] = 1'b1;
                  if (cfg.mode == MODE_CASCADE) irq_nxt = 1'b1;
                end
              end
            end
          end
        end
        if (cfg.t1_en && cfg.mode == MODE_INDEP) begin
          rest1_nxt = CNT_W'(tot1 & ((17'd1 << sh1) - 17'd1));
          v1_nxt    = val1[CNT_W-1:0];
          if (|val1[ELAPSED_W+1:CNT_W]) begin
            st_nxt[1] = 1'b1;
            irq_nxt   = 1'b1;
          end
        end
      end
      CMD_LOAD0: v0_nxt = wv;
      CMD_LOAD1: v1_nxt = wv;
      CMD_CLEAR: st_nxt = st_r & ~wv[1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest0_r <= '0;
      rest1_r <= '0;
      v0_r    <= '0;
      v1_r    <= '0;
      st_r    <= '0;
    end else if (step_en) begin
      rest0_r <= rest0_nxt;
      rest1_r <= rest1_nxt;
      v0_r    <= v0_nxt;
      v1_r    <= v1_nxt;
      st_r    <= st_nxt;
    end
  end

  assign state.irq      = 1'b0;
  assign state.t0_count = v0_r;
  assign state.t1_count = v1_r;
  assign state.t0_flag  = st_r[0];
  assign state.t1_flag  = st_r[1];

endmodule

// File: hw/rtl/dual_timer_prescaled_modes.sv
// Dual 8-bit prescaled timer pair with four modes: top level and handshake.
// Depends on dtpm_pkg, dtpm_cfg, dtpm_step and dual_timer_prescaled_modes_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one command word: tick with an
//   elapsed clock count, load timer0, load timer1, or clear status bits.
//   Result channel (out_valid / out_stall) returns one word per command: the
//   interrupt request for this step, both timer counts and both sticky flags.
//   Configuration goes through the APB-style port (psel ... pready), registers
//   at byte address 4*i; pready is tied high. Write it only while idle.
// Timing:
//   A word is held in the input register, then executed into the timer state /
//   result register when the result register may advance; its result is valid
//   from then on. One word per cycle is sustained while out_stall is low; the
//   timer update is combinational between the two registers.
// Reset (rst_n, synchronous): clears config, counts, prescaler remainders and
//   flags, and empties the pipe.
// Stall: while out_stall holds a result, the input register keeps one more
//   word and then in_stall rises; nothing is lost or repeated.
module dual_timer_prescaled_modes #(
  parameter int TICK_BITS = dtpm_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [dtpm_pkg::ELAPSED_W-1:0]  in_elapsed_ticks,
  input  logic [dtpm_pkg::CNT_W-1:0]      in_write_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_interrupt_request,
  output logic [dtpm_pkg::CNT_W-1:0]      out_timer0_count,
  output logic [dtpm_pkg::CNT_W-1:0]      out_timer1_count,
  output logic                            out_timer0_flag,
  output logic                            out_timer1_flag,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtpm_pkg::APB_AW-1:0]     paddr,
  input  logic [dtpm_pkg::APB_DW-1:0]     pwdata,
  output logic [dtpm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import dtpm_pkg::*;
  `include "dual_timer_prescaled_modes_defines.svh"

  cfg_t cfg;
  res_t state;

  logic                 s1_valid_r;
  cmd_t                 s1_cmd_r;
  logic [ELAPSED_W-1:0] s1_el_r;
  logic [CNT_W-1:0]     s1_wv_r;
  logic                 out_valid_r;
  logic                 irq_r;
  logic                 irq_nxt;
  logic                 advance;
  logic                 step_en;
  logic                 accept;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign step_en  = s1_valid_r && advance;

  dtpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtpm_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (step_en),
    .cmd     (s1_cmd_r),
    .elapsed (s1_el_r),
    .wv      (s1_wv_r),
    .irq_nxt (irq_nxt),
    .state   (state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_cmd_r <= cmd_t'(in_command);
      s1_el_r  <= in_elapsed_ticks;
      s1_wv_r  <= in_write_value;
    end
    if (step_en) begin
      irq_r <= irq_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_interrupt_request = irq_r;
  assign out_timer0_count      = state.t0_count;
  assign out_timer1_count      = state.t1_count;
  assign out_timer0_flag       = state.t0_flag;
  assign out_timer1_flag       = state.t1_flag;

  // an interrupt always comes with a sticky flag
  `DTPM_ASSERT_SAME(a_irq_has_flag, out_valid_r && irq_r, state.t0_flag || state.t1_flag)
  // full clear leaves both flags low in the result
  `DTPM_ASSERT_NEXT(a_clear_all, step_en && s1_cmd_r == CMD_CLEAR && s1_wv_r[1:0] == 2'b11, !state.t0_flag && !state.t1_flag)
  // load of timer0 shows up in the next result
  `DTPM_ASSERT_NEXT(a_load0, step_en && s1_cmd_r == CMD_LOAD0, out_valid_r && state.t0_count == $past(s1_wv_r))
  // non-tick commands never interrupt
  `DTPM_ASSERT_NEXT(a_no_irq_cmd, step_en && s1_cmd_r != CMD_TICK, !irq_r)

endmodule

// File: test/tb_dual_timer_prescaled_modes.sv
// Testbench for dual_timer_prescaled_modes: directed and random command words under many
// timer settings, predicted by an in-bench timer pair and checked field by field.
// Depends on dtpm_pkg and the RTL of dual_timer_prescaled_modes.
import dtpm_pkg::*;

class timer_pair_tracker;
  cfg_t       cfg;
  logic [7:0] t0_rest, t1_rest, t0_val, t1_val;
  logic [1:0] status;
  res_t       pending_steps[$];
  int         mismatches, checked, ticks_seen, irqs_predicted;

  // matches the block right after reset
  function new();
    cfg = '0;
    t0_rest = '0;
    t1_rest = '0;
    t0_val = '0;
    t1_val = '0;
    status = '0;
  endfunction

  function void set_reg(reg_idx_t idx, int unsigned v);
    case (idx)
      REG_MODE:     cfg.mode = mode_t'(2'(v));
      REG_T0_SHORT: cfg.t0_div_short = 2'(v);
      REG_T0_WIDE:  cfg.t0_div_wide = 3'(v);
      REG_T1_DIV:   cfg.t1_div = 2'(v);
      REG_T0_EN:    cfg.t0_en = v[0];
      REG_T1_EN:    cfg.t1_en = v[0];
      default: ;
    endcase
  endfunction

  // add elapsed to the remainder, keep the low shift bits, return the count step
  function int unsigned scale_down(inout logic [7:0] rest, input int unsigned elapsed,
                                   input int unsigned shift);
    int unsigned total;
    total = rest + elapsed;
    rest = 8'(total & ((1 << shift) - 1));
    return total >> shift;
  endfunction

  function bit run_tick(int unsigned elapsed);
    bit          irq, cascade;
    int unsigned shift, value, high;
    irq = 1'b0;
    if (cfg.t0_en) begin
      shift = 1 + ((cfg.mode == MODE_INDEP) ? cfg.t0_div_short : cfg.t0_div_wide);
      value = t0_val + scale_down(t0_rest, elapsed, shift);
      if (cfg.mode == MODE_ADD || cfg.mode == MODE_INDEP) begin
        if (value > 255 && (cfg.mode == MODE_INDEP || cfg.t1_en)) begin
          status[0] = 1'b1;
          irq = 1'b1;
        end
        // add mode folds timer1 into timer0 after the overflow test
        if (cfg.mode == MODE_ADD) value += t1_val;
        t0_val = 8'(value);
      end else begin
        t0_val = 8'(value);
        if (value > 255) begin
          cascade = 1'b1;
          if (cfg.mode == MODE_CASCADE_FLAG) begin
            status[0] = 1'b1;
            irq = 1'b1;
            cascade = cfg.t1_en;
          end
          // full lap count carries, not just one
          if (cascade) begin
            high = t1_val + (value >> 8);
            if (high > 255) begin
              status[1] = 1'b1;
              if (cfg.mode == MODE_CASCADE) irq = 1'b1;
            end
            t1_val = 8'(high);
          end
        end
      end
    end
    if (cfg.t1_en && cfg.mode == MODE_INDEP) begin
      shift = 2 * (cfg.t1_div + 1);
      value = t1_val + scale_down(t1_rest, elapsed, shift);
      t1_val = 8'(value);
      if (value > 255) begin
        status[1] = 1'b1;
        irq = 1'b1;
      end
    end
    return irq;
  endfunction

  function void note_command(cmd_t c, logic [15:0] e, logic [7:0] w);
    res_t r;
    r.irq = 1'b0;
    case (c)
      CMD_TICK: begin
        r.irq = run_tick(e);
        ticks_seen++;
      end
      CMD_LOAD0: t0_val = w;
      CMD_LOAD1: t1_val = w;
      CMD_CLEAR: status = status & ~w[1:0];
      default: ;
    endcase
    r.t0_count = t0_val;
    r.t1_count = t1_val;
    r.t0_flag = status[0];
    r.t1_flag = status[1];
    if (r.irq) irqs_predicted++;
    pending_steps.push_back(r);
  endfunction

  function void check_word(res_t got);
    res_t want;
    if (pending_steps.size() == 0) begin
      $error("result word with nothing pending");
      mismatches++;
      return;
    end
    want = pending_steps.pop_front();
    checked++;
    if (got.irq !== want.irq) begin
      $error("interrupt_request expected %0d got %0d", want.irq, got.irq);
      mismatches++;
    end
    if (got.t0_count !== want.t0_count) begin
      $error("timer0_count expected %0d got %0d", want.t0_count, got.t0_count);
      mismatches++;
    end
    if (got.t1_count !== want.t1_count) begin
      $error("timer1_count expected %0d got %0d", want.t1_count, got.t1_count);
      mismatches++;
    end
    if (got.t0_flag !== want.t0_flag) begin
      $error("timer0_flag expected %0d got %0d", want.t0_flag, got.t0_flag);
      mismatches++;
    end
    if (got.t1_flag !== want.t1_flag) begin
      $error("timer1_flag expected %0d got %0d", want.t1_flag, got.t1_flag);
      mismatches++;
    end
  endfunction
endclass

module tb_dual_timer_prescaled_modes;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_command = CMD_TICK;
  logic [ELAPSED_W-1:0] in_elapsed_ticks = '0;
  logic [CNT_W-1:0]    in_write_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_interrupt_request;
  logic [CNT_W-1:0]    out_timer0_count, out_timer1_count;
  logic                out_timer0_flag, out_timer1_flag;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  timer_pair_tracker tracker;
  bit  calm = 1'b0;       // no idling on either side
  int  hold_asks = 0;     // bumped by the sender side to request a long stall
  int  words_sent = 0, settings_used = 0;

  always #5 clk = ~clk;

  dual_timer_prescaled_modes u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_elapsed_ticks, .in_write_value,
    .out_valid, .out_stall, .out_interrupt_request, .out_timer0_count,
    .out_timer1_count, .out_timer0_flag, .out_timer1_flag,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial tracker = new();

  // result side: check accepted words, stall at random or for a long hold
  always @(posedge clk) begin : result_side
    res_t got;
    int   holds_done, hold_left;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.irq = out_interrupt_request;
        got.t0_count = out_timer0_count;
        got.t1_count = out_timer1_count;
        got.t0_flag = out_timer0_flag;
        got.t1_flag = out_timer1_flag;
        tracker.check_word(got);
      end
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 12);
      end
    end
  end

  function automatic cfg_t make_settings(mode_t m, int sh, int wd, int t1d, bit e0, bit e1);
    cfg_t s;
    s.mode = m;
    s.t0_div_short = 2'(sh);
    s.t0_div_wide = 3'(wd);
    s.t1_div = 2'(t1d);
    s.t0_en = e0;
    s.t1_en = e1;
    return s;
  endfunction

  task automatic send_word(cmd_t c, int unsigned e, int unsigned w);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_elapsed_ticks <= 16'(e);
    in_write_value <= 8'(w);
    do @(posedge clk); while (in_stall);
    tracker.note_command(c, 16'(e), 8'(w));
    words_sent++;
  endtask

  // drop valid, wait for every pending result, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t s);
    reg_idx_t    idx;
    int unsigned v;
    wait_idle();
    for (int i = 0; i <= 5; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_MODE:     v = s.mode;
        REG_T0_SHORT: v = s.t0_div_short;
        REG_T0_WIDE:  v = s.t0_div_wide;
        REG_T1_DIV:   v = s.t1_div;
        REG_T0_EN:    v = s.t0_en;
        REG_T1_EN:    v = s.t1_en;
        default:      v = 0;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(v);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      tracker.set_reg(idx, v);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_word();
    int unsigned r, e, w;
    cmd_t        c;
    r = $urandom_range(99);
    if (r < 60) c = CMD_TICK;
    else if (r < 75) c = CMD_LOAD0;
    else if (r < 90) c = CMD_LOAD1;
    else c = CMD_CLEAR;
    case ($urandom_range(3))
      0: e = $urandom_range(15);
      1: e = $urandom_range(511);
      2: e = $urandom_range(65535);
      default: e = 65535 - $urandom_range(255);
    endcase
    // loads near the top make overflows frequent even with small steps
    w = ($urandom_range(1) != 0) ? $urandom_range(255) : $urandom_range(255, 240);
    send_word(c, e, w);
  endtask

  initial begin : stimulus
    cfg_t s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // independent mode, fastest dividers, multi-lap overflow on both timers
    apply_settings(make_settings(MODE_INDEP, 0, 0, 0, 1, 1));
    send_word(CMD_LOAD0, 0, 255);
    send_word(CMD_LOAD1, 0, 255);
    send_word(CMD_TICK, 0, 0);
    send_word(CMD_TICK, 65535, 0);
    send_word(CMD_CLEAR, 0, 1);
    send_word(CMD_CLEAR, 0, 2);
    send_word(CMD_TICK, 1, 255);
    send_word(CMD_CLEAR, 0, 255);
    send_word(CMD_LOAD0, 0, 0);

    // cascade, widest divider, timer1 off: carries still reach timer1
    apply_settings(make_settings(MODE_CASCADE, 0, 7, 0, 1, 0));
    send_word(CMD_LOAD0, 0, 250);
    send_word(CMD_LOAD1, 0, 255);
    send_word(CMD_TICK, 65535, 0);
    send_word(CMD_TICK, 3, 0);
    send_word(CMD_CLEAR, 0, 3);

    // flagged cascade with timer1 off: timer0 flag, no carry;
    // leftover remainder from the wide divider meets a short shift
    apply_settings(make_settings(MODE_CASCADE_FLAG, 3, 0, 3, 1, 0));
    send_word(CMD_LOAD0, 0, 200);
    send_word(CMD_TICK, 200, 0);
    send_word(CMD_TICK, 65535, 0);

    // add mode: timer1 folded into timer0 each tick
    apply_settings(make_settings(MODE_ADD, 0, 3, 0, 1, 1));
    send_word(CMD_LOAD1, 0, 100);
    send_word(CMD_TICK, 65535, 0);
    send_word(CMD_TICK, 16, 0);

    // timer0 stopped, timer1 on its slowest divider
    apply_settings(make_settings(MODE_INDEP, 3, 7, 3, 0, 1));
    send_word(CMD_TICK, 65535, 0);
    send_word(CMD_TICK, 0, 0);

    for (int phase = 0; phase < 15; phase++) begin
      if (phase == 0) s = make_settings(MODE_ADD, 0, 0, 0, 0, 0);
      else if (phase == 1) s = make_settings(MODE_CASCADE_FLAG, 3, 7, 3, 1, 1);
      else s = make_settings(mode_t'(2'($urandom_range(3))), $urandom_range(3),
                             $urandom_range(7), $urandom_range(3),
                             $urandom_range(3) != 0, $urandom_range(3) != 0);
      apply_settings(s);
      calm = (phase == 3);
      for (int k = 0; k < 90; k++) begin
        if (phase == 6 && k == 30) hold_asks <= hold_asks + 1;
        send_random_word();
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (6) @(posedge clk);
    $display("covered %0d words under %0d settings: %0d ticks, %0d raising an interrupt",
             words_sent, settings_used, tracker.ticks_seen, tracker.irqs_predicted);
    $display("%0d result words checked, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb_dual_timer_prescaled_modes OK");
    end else begin
      $display("tb_dual_timer_prescaled_modes NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("timeout waiting on the block");
    $display("tb_dual_timer_prescaled_modes NOT OK");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dtpm_pkg.sv
hw/rtl/dtpm_cfg.sv
hw/rtl/dtpm_step.sv
hw/rtl/dual_timer_prescaled_modes.sv
test/tb_dual_timer_prescaled_modes.sv
